### hw/rtl/assert_macros.svh
// Assertion macros shared by the shooter speed PID RTL.
// No dependencies; each macro expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SSPID_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sspid assertion failed");
// Condition that must never be true outside reset.
`define SSPID_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sspid forbidden condition seen");
`else
`define SSPID_ASSERT(label, clk, rst_n, prop)
`define SSPID_NEVER(label, clk, rst_n, cond)
`endif
`endif

### hw/rtl/sspid_pkg.sv
// Package for the shooter speed PID: widths, constants, codes and the
// controller/datapath command and status structs. No dependencies.
package sspid_pkg;

    localparam int PERIOD_BITS_DEF = 24;
    localparam int RPM_BITS_DEF    = 16;

    localparam int GAIN_W      = 16;
    localparam int TARGET_W    = 16;
    localparam int DRIVE_W     = 15;
    localparam int CLAMP_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int INT_W       = 32;
    localparam int ACC_W       = 64;

    // Microseconds per minute; 26 bits of dividend for the speed divider.
    localparam int US_PER_MINUTE = 60000000;
    localparam int DIV_W         = 26;

    // Reset gains, unsigned Q8.8 (150.0, 35.0, 15.0).
    localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd38400;
    localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd8960;
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = 16'd3840;

    // Term scale factors: acc = 25 * 32768 * drive in full-scale units.
    localparam int KP_SCALE = 3200;
    localparam int KI_SCALE = 128;
    localparam int KD_SCALE = 80000;

    localparam int DRIVE_FULL     = 32767;
    localparam int ACC_DEN        = 25;
    localparam int ACC_FULL_LIMIT = DRIVE_FULL * ACC_DEN + ACC_DEN - 1;

    // floor(x / 25) = (x * RECIP_MUL) >> RECIP_SHIFT for x below 2^SCALE_IN_W.
    localparam int SCALE_IN_W  = 20;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 27;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 23'd5368710;

    localparam logic signed [INT_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [INT_W-1:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic {
        FUNC_INIT   = 1'b0,
        FUNC_UPDATE = 1'b1
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2
    } reg_index_t;

    typedef enum logic [CLAMP_W-1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_ZERO = 2'd1,
        CLAMP_FULL = 2'd2
    } clamp_t;

    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } term_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_LOAD,
        ST_MUL,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  div_step;
        logic  err_update;
        logic  load;
        logic  mul_step;
        logic  scale;
        logic  out_load;
        term_t term;
    } cmd_t;

    typedef struct packed {
        logic is_update;
        logic out_free;
    } status_t;

endpackage

### hw/rtl/sspid_req_if.sv
// Input item channel of the shooter speed PID.
// Depends on sspid_pkg for field widths.
interface sspid_req_if #(
    parameter int PeriodBits = sspid_pkg::PERIOD_BITS_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [sspid_pkg::TARGET_W-1:0]  target_rpm;
    logic [PeriodBits-1:0]           period_us;

    modport source (output valid, func, target_rpm, period_us, input ready);
    modport sink   (input valid, func, target_rpm, period_us, output ready);
endinterface

### hw/rtl/sspid_rsp_if.sv
// Result item channel of the shooter speed PID.
// Depends on sspid_pkg for field widths.
interface sspid_rsp_if #(
    parameter int RpmBits = sspid_pkg::RPM_BITS_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic [sspid_pkg::DRIVE_W-1:0]  drive;
    logic [RpmBits-1:0]             measured_rpm;
    logic [sspid_pkg::CLAMP_W-1:0]  clamp_state;

    modport source (output valid, drive, measured_rpm, clamp_state, input ready);
    modport sink   (input valid, drive, measured_rpm, clamp_state, output ready);
endinterface

### hw/rtl/sspid_cfg_if.sv
// Configuration write channel of the shooter speed PID.
// Depends on sspid_pkg for the index and data widths.
interface sspid_cfg_if ();
    logic                              valid;
    logic                              ready;
    logic [sspid_pkg::CFG_INDEX_W-1:0] index;
    logic [sspid_pkg::GAIN_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/sspid_ctrl.sv
// Sequencer of the shooter speed PID: state machine, step counter, term select.
// Depends on sspid_pkg for the state, command and status types.
module sspid_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sspid_pkg::status_t status,
    output sspid_pkg::cmd_t    cmd
);

    localparam int CntW = $clog2(sspid_pkg::DIV_W);

    sspid_pkg::state_t state_reg, state_next;
    sspid_pkg::term_t  term_reg, term_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sspid_pkg::ST_IDLE;
            term_reg  <= sspid_pkg::TERM_P;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            sspid_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sspid_pkg::ST_DIV;
                    cnt_next   = '0;
                end
            end
            sspid_pkg::ST_DIV:
            begin
                if (cnt_reg == CntW'(sspid_pkg::DIV_W - 1))
                    state_next = sspid_pkg::ST_ERR;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            sspid_pkg::ST_ERR:
            begin
                term_next  = sspid_pkg::TERM_P;
                state_next = status.is_update ? sspid_pkg::ST_LOAD : sspid_pkg::ST_IDLE;
            end
            sspid_pkg::ST_LOAD:
            begin
                state_next = sspid_pkg::ST_MUL;
                cnt_next   = '0;
            end
            sspid_pkg::ST_MUL:
            begin
                if (cnt_reg == CntW'(sspid_pkg::GAIN_W - 1))
                begin
                    unique case (term_reg)
                        sspid_pkg::TERM_P:
                        begin
                            term_next  = sspid_pkg::TERM_I;
                            state_next = sspid_pkg::ST_LOAD;
                        end
                        sspid_pkg::TERM_I:
                        begin
                            term_next  = sspid_pkg::TERM_D;
                            state_next = sspid_pkg::ST_LOAD;
                        end
                        default:
                            state_next = sspid_pkg::ST_SCALE;
                    endcase
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            sspid_pkg::ST_SCALE:
                state_next = sspid_pkg::ST_OUT;
            sspid_pkg::ST_OUT:
            begin
                if (status.out_free)
                    state_next = sspid_pkg::ST_IDLE;
            end
            default:
                state_next = sspid_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == sspid_pkg::ST_IDLE);
        cmd.capture    = (state_reg == sspid_pkg::ST_IDLE) && in_valid;
        cmd.div_step   = (state_reg == sspid_pkg::ST_DIV);
        cmd.err_update = (state_reg == sspid_pkg::ST_ERR);
        cmd.load       = (state_reg == sspid_pkg::ST_LOAD);
        cmd.mul_step   = (state_reg == sspid_pkg::ST_MUL);
        cmd.scale      = (state_reg == sspid_pkg::ST_SCALE);
        cmd.out_load   = (state_reg == sspid_pkg::ST_OUT) && status.out_free;
        cmd.term       = term_reg;
    end

endmodule

### hw/rtl/sspid_datapath.sv
// Datapath of the shooter speed PID: gain registers, speed divider, error
// state, shift-add term multiplier, scaling and the result register. Uses sspid_pkg.
module sspid_datapath #(
    parameter int PERIOD_BITS = sspid_pkg::PERIOD_BITS_DEF,
    parameter int RPM_BITS    = sspid_pkg::RPM_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_func,
    input  logic [sspid_pkg::TARGET_W-1:0]      in_target,
    input  logic [PERIOD_BITS-1:0]              in_period,
    input  logic                                cfg_we,
    input  logic [sspid_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sspid_pkg::GAIN_W-1:0]        cfg_data,
    input  sspid_pkg::cmd_t                     cmd,
    output sspid_pkg::status_t                  status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [sspid_pkg::DRIVE_W-1:0]       out_drive,
    output logic [RPM_BITS-1:0]                 out_measured,
    output logic [sspid_pkg::CLAMP_W-1:0]       out_clamp
);

    localparam int DivW  = sspid_pkg::DIV_W;
    localparam int AccW  = sspid_pkg::ACC_W;
    localparam int IntW  = sspid_pkg::INT_W;
    localparam int GainW = sspid_pkg::GAIN_W;
    localparam int ErrW  = ((RPM_BITS > sspid_pkg::TARGET_W) ? RPM_BITS
                                                              : sspid_pkg::TARGET_W) + 1;
    localparam int DiffW = ErrW + 1;
    localparam int ProdW = sspid_pkg::SCALE_IN_W + sspid_pkg::RECIP_W;
    localparam logic [RPM_BITS-1:0] RpmMax = {RPM_BITS{1'b1}};
    localparam logic [DivW-1:0] Dividend = DivW'(sspid_pkg::US_PER_MINUTE);
    localparam logic signed [AccW-1:0] KpScale = AccW'(sspid_pkg::KP_SCALE);
    localparam logic signed [AccW-1:0] KiScale = AccW'(sspid_pkg::KI_SCALE);
    localparam logic signed [AccW-1:0] KdScale = AccW'(sspid_pkg::KD_SCALE);
    localparam logic signed [AccW-1:0] AccFull = AccW'(sspid_pkg::ACC_FULL_LIMIT);

    logic [GainW-1:0]              gain_p_reg, gain_i_reg, gain_d_reg;
    logic                          func_reg;
    logic [sspid_pkg::TARGET_W-1:0] target_reg;
    logic [PERIOD_BITS-1:0]        period_reg;
    logic [PERIOD_BITS-1:0]        rem_reg;
    logic [DivW-1:0]               quot_reg;
    logic signed [ErrW-1:0]        last_error_reg;
    logic signed [IntW-1:0]        integral_reg;
    logic signed [ErrW-1:0]        err_reg;
    logic signed [DiffW-1:0]       diff_reg;
    logic [RPM_BITS-1:0]           meas_reg;
    logic signed [AccW-1:0]        mcand_reg, mcand_next;
    logic [GainW-1:0]              gshift_reg, gshift_next;
    logic signed [AccW-1:0]        acc_reg;
    logic [sspid_pkg::DRIVE_W-1:0] res_drive_reg, res_drive_next;
    sspid_pkg::clamp_t             res_clamp_reg, res_clamp_next;
    logic                          out_valid_reg;
    logic [sspid_pkg::DRIVE_W-1:0] out_drive_reg;
    logic [RPM_BITS-1:0]           out_meas_reg;
    sspid_pkg::clamp_t             out_clamp_reg;

    logic [PERIOD_BITS:0]          div_shift;
    logic                          div_fit;
    logic [RPM_BITS-1:0]           meas_sat;
    logic signed [ErrW-1:0]        err_now;
    logic signed [IntW:0]          int_sum;
    logic signed [IntW-1:0]        int_sat;
    logic signed [DiffW-1:0]       diff_now;
    logic [ProdW-1:0]              recip_prod;

    // Configuration writes; indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= sspid_pkg::GAIN_P_RESET;
            gain_i_reg <= sspid_pkg::GAIN_I_RESET;
            gain_d_reg <= sspid_pkg::GAIN_D_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sspid_pkg::REG_GAIN_P: gain_p_reg <= cfg_data;
                sspid_pkg::REG_GAIN_I: gain_i_reg <= cfg_data;
                sspid_pkg::REG_GAIN_D: gain_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // One restoring division step per cycle: 60000000 / period.
    assign div_shift = {rem_reg, quot_reg[DivW-1]};
    assign div_fit   = (div_shift >= {1'b0, period_reg});

    // A zero period leaves an all-ones quotient, which saturates below.
    assign meas_sat = (|quot_reg[DivW-1:RPM_BITS]) ? RpmMax : quot_reg[RPM_BITS-1:0];
    assign err_now  = $signed(ErrW'(target_reg)) - $signed(ErrW'(meas_sat));
    assign int_sum  = (IntW+1)'(integral_reg) + (IntW+1)'(err_now);
    assign diff_now = DiffW'(err_now) - DiffW'(last_error_reg);

    always_comb
    begin
        if (int_sum[IntW] != int_sum[IntW-1])
            int_sat = int_sum[IntW] ? sspid_pkg::INT_MIN : sspid_pkg::INT_MAX;
        else
            int_sat = int_sum[IntW-1:0];
    end

    // Scaled term operand: a constant multiply of the selected value.
    always_comb
    begin
        unique case (cmd.term)
            sspid_pkg::TERM_P:
            begin
                mcand_next  = AccW'(err_reg) * KpScale;
                gshift_next = gain_p_reg;
            end
            sspid_pkg::TERM_I:
            begin
                mcand_next  = AccW'(integral_reg) * KiScale;
                gshift_next = gain_i_reg;
            end
            default:
            begin
                mcand_next  = AccW'(diff_reg) * KdScale;
                gshift_next = gain_d_reg;
            end
        endcase
    end

    // Divide by 25 through a reciprocal, valid for sums under full scale.
    assign recip_prod = ProdW'(acc_reg[sspid_pkg::SCALE_IN_W-1:0]) *
                        ProdW'(sspid_pkg::RECIP_MUL);

    always_comb
    begin
        priority if (acc_reg < 0)
        begin
            res_drive_next = '0;
            res_clamp_next = sspid_pkg::CLAMP_ZERO;
        end
        else if (acc_reg > AccFull)
        begin
            res_drive_next = sspid_pkg::DRIVE_W'(sspid_pkg::DRIVE_FULL);
            res_clamp_next = sspid_pkg::CLAMP_FULL;
        end
        else
        begin
            res_drive_next = recip_prod[sspid_pkg::RECIP_SHIFT +: sspid_pkg::DRIVE_W];
            res_clamp_next = sspid_pkg::CLAMP_NONE;
        end
    end

    // Controller-visible state: last error and integral.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            integral_reg   <= '0;
        end
        else if (cmd.err_update)
        begin
            last_error_reg <= err_now;
            if (func_reg == sspid_pkg::FUNC_INIT)
                integral_reg <= '0;
            else
                integral_reg <= int_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= in_func;
            target_reg <= in_target;
            period_reg <= in_period;
            rem_reg    <= '0;
            quot_reg   <= Dividend;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= div_fit ? PERIOD_BITS'(div_shift - {1'b0, period_reg})
                                : div_shift[PERIOD_BITS-1:0];
            quot_reg <= {quot_reg[DivW-2:0], div_fit};
        end
        if (cmd.err_update)
        begin
            meas_reg <= meas_sat;
            err_reg  <= err_now;
            diff_reg <= diff_now;
            acc_reg  <= '0;
        end
        if (cmd.load)
        begin
            mcand_reg  <= mcand_next;
            gshift_reg <= gshift_next;
        end
        if (cmd.mul_step)
        begin
            if (gshift_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg <<< 1;
            gshift_reg <= gshift_reg >> 1;
        end
        if (cmd.scale)
        begin
            res_drive_reg <= res_drive_next;
            res_clamp_reg <= res_clamp_next;
        end
        if (cmd.out_load)
        begin
            out_drive_reg <= res_drive_reg;
            out_clamp_reg <= res_clamp_reg;
            out_meas_reg  <= meas_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.is_update = (func_reg == sspid_pkg::FUNC_UPDATE);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_drive    = out_drive_reg;
    assign out_measured = out_meas_reg;
    assign out_clamp    = out_clamp_reg;

endmodule

### hw/rtl/shooter_speed_pid_core.sv
// Shooter speed PID core: flywheel speed controller built from a sequencer and a datapath.
// Depends on sspid_pkg, the sspid_*_if interfaces, sspid_ctrl, sspid_datapath
// and assert_macros.svh.
//
// Each input item carries func, a target speed in RPM and a measured pulse period in
// microseconds. The block derives the measured speed as 60000000 / period, saturated
// at the all-ones RPM value (a zero period saturates too), and forms the error as
// target minus measured. An init item (func = 0) loads the previous error, clears the
// integral and gives no result. An update item adds the error to the integral, which
// saturates at the signed 32-bit range, takes the error difference as derivative and
// returns one result: a Q0.15 drive computed from the Q8.8 gains, clamped to 0..32767,
// the measured speed, and a clamp code (0 none, 1 held at zero, 2 held at full).
// Items are handled one at a time. An update item goes from acceptance to a loaded
// result through these steps: acceptance, the restoring divider that works out the speed
// one quotient bit per cycle, the error and integral update, the shift-add multiplier
// that walks the 16 gain bits of each of the three terms, scaling by 1/25 with clamping,
// and loading the output register. An init item ends with the error and integral update.
// The output register lets a new item be accepted while a result waits to be taken;
// that item stalls only at its end if the previous result is still there. Gains are
// written over the configuration channel, which is always ready; write them only while
// the block is idle.
`include "assert_macros.svh"

module shooter_speed_pid_core #(
    parameter int PERIOD_BITS = sspid_pkg::PERIOD_BITS_DEF,
    parameter int RPM_BITS    = sspid_pkg::RPM_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sspid_req_if.sink    req,
    sspid_rsp_if.source  rsp,
    sspid_cfg_if.sink    cfg
);

    sspid_pkg::cmd_t    cmd;
    sspid_pkg::status_t status;
    logic               in_ready;
    logic [6:0]         cmd_flags;
    logic               clamp_bad;

    // The configuration registers take a write in any cycle.
    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;

    sspid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sspid_datapath #(
        .PERIOD_BITS (PERIOD_BITS),
        .RPM_BITS    (RPM_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_func      (req.func),
        .in_target    (req.target_rpm),
        .in_period    (req.period_us),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_drive    (rsp.drive),
        .out_measured (rsp.measured_rpm),
        .out_clamp    (rsp.clamp_state)
    );

    // Datapath commands gathered into one vector, and a clamp code that disagrees
    // with the drive value beside it.
    assign cmd_flags = {cmd.capture, cmd.div_step, cmd.err_update, cmd.load,
                        cmd.mul_step, cmd.scale, cmd.out_load};
    assign clamp_bad = (rsp.clamp_state == sspid_pkg::CLAMP_ZERO && rsp.drive != '0)
                    || (rsp.clamp_state == sspid_pkg::CLAMP_FULL
                        && rsp.drive != sspid_pkg::DRIVE_W'(sspid_pkg::DRIVE_FULL));

    // The sequencer issues at most one datapath command per cycle.
    `SSPID_ASSERT(a_cmd_onehot, clk, rst_n, $onehot0(cmd_flags))
    // A result appears only when the sequencer has loaded one.
    `SSPID_ASSERT(a_rsp_from_load, clk, rst_n, $rose(rsp.valid) |-> $past(cmd.out_load))
    // A clamp code always agrees with the drive it reports.
    `SSPID_NEVER(a_clamp_drive, clk, rst_n, rsp.valid && clamp_bad)

endmodule

### bench/shooter_speed_pid_core_tb.sv
// Self-checking testbench for shooter_speed_pid_core: directed and random speed items,
// gain changes between phases and random stalls on the item and result channels.
// Depends on sspid_pkg, the sspid_req_if, sspid_rsp_if and sspid_cfg_if interfaces and the core.
module shooter_speed_pid_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD_W = sspid_pkg::PERIOD_BITS_DEF;
    localparam int RPM_W = sspid_pkg::RPM_BITS_DEF;
    localparam longint US_IN_MINUTE = 60000000;
    localparam int RESET_CYCLES = 6;
    // An init item keeps the core busy without giving a result, so this many quiet cycles
    // make sure the core is idle before the gains are touched.
    localparam int IDLE_TAIL = 100;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        sspid_pkg::func_t                func;
        logic [sspid_pkg::TARGET_W-1:0]  target;
        logic [PERIOD_W-1:0]             period;
    } speed_item_t;

    typedef struct {
        logic [sspid_pkg::DRIVE_W-1:0] drive;
        logic [RPM_W-1:0]              rpm;
        sspid_pkg::clamp_t             clamp;
    } drive_result_t;

    typedef struct {
        sspid_pkg::reg_index_t          index;
        logic [sspid_pkg::GAIN_W-1:0]   value;
    } gain_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sspid_req_if #(.PeriodBits(PERIOD_W)) req_ch ();
    sspid_rsp_if #(.RpmBits(RPM_W))       rsp_ch ();
    sspid_cfg_if                          cfg_ch ();

    shooter_speed_pid_core #(
        .PERIOD_BITS(PERIOD_W),
        .RPM_BITS   (RPM_W)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch),
        .cfg  (cfg_ch)
    );

    // Items waiting to be offered, results the controller still owes us, and gain writes
    // waiting for the configuration channel.
    speed_item_t   pending_speed_items[$];
    drive_result_t due_drive_results[$];
    gain_write_t   pending_gain_writes[$];

    // Percentage of cycles in which the sender holds back and the receiver stalls.
    int send_idle_pct = 35;
    int recv_idle_pct = 35;

    int mismatch_count = 0;
    int cycle_count = 0;
    int pushed_items = 0;

    // Our own copy of the controller: gains as written over the configuration channel,
    // the previous error and the saturating error sum.
    logic [sspid_pkg::GAIN_W-1:0]       kp_model = sspid_pkg::GAIN_P_RESET;
    logic [sspid_pkg::GAIN_W-1:0]       ki_model = sspid_pkg::GAIN_I_RESET;
    logic [sspid_pkg::GAIN_W-1:0]       kd_model = sspid_pkg::GAIN_D_RESET;
    logic signed [17:0]                 prev_error_model = '0;
    logic signed [sspid_pkg::INT_W-1:0] error_sum_model = '0;

    speed_item_t   offered_item;
    gain_write_t   offered_write;
    drive_result_t oldest_due;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // A run that hangs, for example because a result never shows up, ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] drive check failed: %s", $realtime, what);
    endtask

    // Measured speed: microseconds per minute over the period, held at the all-ones
    // value when the quotient does not fit, and also for a zero period.
    function automatic logic [RPM_W-1:0] rpm_of_period(input logic [PERIOD_W-1:0] period);
        longint quotient;
        if (period == '0)
        begin
            return '1;
        end
        quotient = US_IN_MINUTE / longint'(period);
        if (quotient > longint'((1 << RPM_W) - 1))
        begin
            return '1;
        end
        return quotient[RPM_W-1:0];
    endfunction

    // Advances the controller copy by one accepted item. An update item queues the
    // drive result it must produce; an init item only reloads the error history.
    task automatic step_speed_pid(input speed_item_t item);
        longint        err;
        longint        total;
        longint        delta;
        longint        acc;
        longint        quotient;
        drive_result_t result;
        result.rpm = rpm_of_period(item.period);
        err = longint'(item.target) - longint'(result.rpm);
        if (item.func == sspid_pkg::FUNC_INIT)
        begin
            prev_error_model = err[17:0];
            error_sum_model = '0;
            return;
        end
        // The error sum saturates at the signed 32-bit range instead of wrapping.
        total = longint'(error_sum_model) + err;
        if (total > longint'(sspid_pkg::INT_MAX))
        begin
            total = longint'(sspid_pkg::INT_MAX);
        end
        if (total < longint'(sspid_pkg::INT_MIN))
        begin
            total = longint'(sspid_pkg::INT_MIN);
        end
        error_sum_model = total[sspid_pkg::INT_W-1:0];
        delta = err - longint'(prev_error_model);
        prev_error_model = err[17:0];
        // The sum is 25 * 32768 times the drive in full-scale units, exact in 64 bits.
        acc = longint'(sspid_pkg::KP_SCALE) * longint'(kp_model) * err
            + longint'(sspid_pkg::KI_SCALE) * longint'(ki_model) * total
            + longint'(sspid_pkg::KD_SCALE) * longint'(kd_model) * delta;
        if (acc < 0)
        begin
            result.drive = '0;
            result.clamp = sspid_pkg::CLAMP_ZERO;
        end
        else
        begin
            quotient = acc / sspid_pkg::ACC_DEN;
            if (quotient > sspid_pkg::DRIVE_FULL)
            begin
                result.drive = sspid_pkg::DRIVE_W'(sspid_pkg::DRIVE_FULL);
                result.clamp = sspid_pkg::CLAMP_FULL;
            end
            else
            begin
                result.drive = quotient[sspid_pkg::DRIVE_W-1:0];
                result.clamp = sspid_pkg::CLAMP_NONE;
            end
        end
        due_drive_results.push_back(result);
    endtask

    // Item driver: offers the next pending item unless it decides to idle this cycle.
    // valid only drops when the queue is empty or the sender idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.func       <= sspid_pkg::FUNC_INIT;
            req_ch.target_rpm <= '0;
            req_ch.period_us  <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_speed_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offered_item = pending_speed_items.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.func       <= offered_item.func;
                req_ch.target_rpm <= offered_item.target;
                req_ch.period_us  <= offered_item.period;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Gain writer: one write per handshake on the configuration channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= sspid_pkg::REG_GAIN_P;
            cfg_ch.data  <= '0;
        end
        else if (!cfg_ch.valid || cfg_ch.ready)
        begin
            if (pending_gain_writes.size() != 0)
            begin
                offered_write = pending_gain_writes.pop_front();
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= offered_write.index;
                cfg_ch.data  <= offered_write.value;
            end
            else
            begin
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: sees every handshake at the clock edge, keeps the controller copy in step
    // and compares each delivered result with the oldest one that is due.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (sspid_pkg::reg_index_t'(cfg_ch.index))
                    sspid_pkg::REG_GAIN_P: kp_model = cfg_ch.data;
                    sspid_pkg::REG_GAIN_I: ki_model = cfg_ch.data;
                    sspid_pkg::REG_GAIN_D: kd_model = cfg_ch.data;
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
            begin
                step_speed_pid('{sspid_pkg::func_t'(req_ch.func), req_ch.target_rpm,
                    req_ch.period_us});
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_drive_results.size() == 0)
                begin
                    report_mismatch("result delivered while none was due");
                end
                else
                begin
                    oldest_due = due_drive_results.pop_front();
                    if (rsp_ch.drive !== oldest_due.drive)
                    begin
                        report_mismatch($sformatf("drive %0d, wanted %0d",
                            rsp_ch.drive, oldest_due.drive));
                    end
                    if (rsp_ch.measured_rpm !== oldest_due.rpm)
                    begin
                        report_mismatch($sformatf("measured_rpm %0d, wanted %0d",
                            rsp_ch.measured_rpm, oldest_due.rpm));
                    end
                    if (rsp_ch.clamp_state !== oldest_due.clamp)
                    begin
                        report_mismatch($sformatf("clamp_state %0d, wanted %0d",
                            rsp_ch.clamp_state, oldest_due.clamp));
                    end
                end
            end
        end
    end

    task automatic push_speed_item(input sspid_pkg::func_t func, input int target,
                                   input int period);
        pending_speed_items.push_back('{func, sspid_pkg::TARGET_W'(target),
            PERIOD_W'(period)});
        pushed_items++;
    endtask

    // Waits until every queued item has been taken and every due result has arrived, then
    // lets the given number of quiet cycles pass. All waiting happens on falling edges so
    // that queue updates never race the clocked processes.
    task automatic wait_idle(input int tail);
        do
        begin
            @(negedge clk);
        end
        while (pending_speed_items.size() != 0 || req_ch.valid || due_drive_results.size() != 0);
        repeat (tail) @(negedge clk);
    endtask

    // Writes all three gains. Only called while the core is idle.
    task automatic load_gains(input int kp, input int ki, input int kd);
        pending_gain_writes.push_back('{sspid_pkg::REG_GAIN_P, sspid_pkg::GAIN_W'(kp)});
        pending_gain_writes.push_back('{sspid_pkg::REG_GAIN_I, sspid_pkg::GAIN_W'(ki)});
        pending_gain_writes.push_back('{sspid_pkg::REG_GAIN_D, sspid_pkg::GAIN_W'(kd)});
        do
        begin
            @(negedge clk);
        end
        while (pending_gain_writes.size() != 0 || cfg_ch.valid);
    endtask

    function automatic int pick_period();
        case ($urandom_range(3))
            0: return $urandom_range(0, 2000);
            1: return $urandom_range(916, 60000);
            2: return $urandom_range(60001, (1 << PERIOD_W) - 1);
            default: return $urandom_range(0, (1 << PERIOD_W) - 1);
        endcase
    endfunction

    function automatic int pick_target();
        if ($urandom_range(3) == 0)
        begin
            return $urandom_range(1) ? (1 << sspid_pkg::TARGET_W) - 1 : 0;
        end
        return $urandom_range(0, (1 << sspid_pkg::TARGET_W) - 1);
    endfunction

    // A well-formed control run: one init item at a steady speed, then a handful of
    // updates whose period drifts a little and whose target moves now and then. Small
    // errors and small error steps keep the drive off its clamps when gains are low.
    task automatic push_control_run();
        int rpm_base;
        int period_base;
        int spread;
        int target;
        int updates;
        rpm_base = $urandom_range(300, 20000);
        period_base = int'(US_IN_MINUTE / rpm_base);
        spread = period_base / 400 + 1;
        target = rpm_base + int'($urandom_range(0, 80)) - 40;
        push_speed_item(sspid_pkg::FUNC_INIT, target, period_base);
        updates = $urandom_range(1, 12);
        repeat (updates)
        begin
            if ($urandom_range(3) == 0)
            begin
                target = target + int'($urandom_range(0, 20)) - 10;
            end
            push_speed_item(sspid_pkg::FUNC_UPDATE, target,
                period_base + int'($urandom_range(0, 2 * spread)) - spread);
        end
    endtask

    // One random phase: mostly control runs, the rest loose items of either kind with
    // random fields, which also covers updates that have no fresh init before them.
    // Now and then the sender holds off until the core has drained completely.
    task automatic run_random_phase(input int item_goal, input int idle_pct);
        int goal;
        send_idle_pct = idle_pct;
        recv_idle_pct = idle_pct;
        goal = pushed_items + item_goal;
        while (pushed_items < goal)
        begin
            if ($urandom_range(99) < 75)
            begin
                push_control_run();
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    push_speed_item($urandom_range(1) ? sspid_pkg::FUNC_UPDATE
                                                      : sspid_pkg::FUNC_INIT,
                        pick_target(), pick_period());
                end
            end
            if ($urandom_range(24) == 0)
            begin
                wait_idle(0);
            end
        end
        wait_idle(IDLE_TAIL);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Reset gains. The first item is an update with no init before it, so the error
        // history is still the reset one; its zero period saturates the measured speed.
        push_speed_item(sspid_pkg::FUNC_UPDATE, 0, 0);
        push_speed_item(sspid_pkg::FUNC_INIT, 65535, (1 << PERIOD_W) - 1);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 65535, (1 << PERIOD_W) - 1);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 0, 1);
        push_speed_item(sspid_pkg::FUNC_INIT, 12000, 5000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 12000, 5000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 12001, 5000);
        wait_idle(IDLE_TAIL);

        // Proportional term alone: errors that land just inside and just past full
        // scale, a negative error, and the edge of speed saturation.
        load_gains(1, 0, 0);
        push_speed_item(sspid_pkg::FUNC_INIT, 1000, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 1100, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 1255, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 1256, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 999, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 1000, 916);
        wait_idle(IDLE_TAIL);

        // Integral term alone: the sum carries over to an update with zero error.
        load_gains(0, 1, 0);
        push_speed_item(sspid_pkg::FUNC_INIT, 0, (1 << PERIOD_W) - 1);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 6400, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 1000, 60000);
        wait_idle(IDLE_TAIL);

        // Derivative term alone: a rising, a steady and a falling error.
        load_gains(0, 0, 1);
        push_speed_item(sspid_pkg::FUNC_INIT, 1000, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 1010, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 1010, 60000);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 1000, 60000);
        wait_idle(IDLE_TAIL);

        // All gains at their maximum.
        load_gains(65535, 65535, 65535);
        push_speed_item(sspid_pkg::FUNC_UPDATE, 65535, 0);
        push_speed_item(sspid_pkg::FUNC_INIT, 0, 1 << (PERIOD_W - 1));
        push_speed_item(sspid_pkg::FUNC_UPDATE, 0, 1 << (PERIOD_W - 1));
        wait_idle(IDLE_TAIL);

        // Random phases. The first runs with no idling on either side at all.
        load_gains($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
        run_random_phase(300, 0);
        load_gains($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
        run_random_phase(300, 35);
        load_gains($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
        run_random_phase(350, 35);
        load_gains(sspid_pkg::GAIN_P_RESET, sspid_pkg::GAIN_I_RESET, sspid_pkg::GAIN_D_RESET);
        run_random_phase(300, 35);
        load_gains($urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(0, 2));
        run_random_phase(400, 35);

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sspid_pkg.sv
hw/rtl/sspid_req_if.sv
hw/rtl/sspid_rsp_if.sv
hw/rtl/sspid_cfg_if.sv
hw/rtl/sspid_ctrl.sv
hw/rtl/sspid_datapath.sv
hw/rtl/shooter_speed_pid_core.sv
bench/shooter_speed_pid_core_tb.sv
